### sv/shfd_pkg.sv
// Shared types and constants for the stereo Hermite fractional delay line.
package shfd_pkg;

	// Line and number formats.
	localparam int LINE_DEPTH = 4096;
	localparam int IDX_W      = $clog2(LINE_DEPTH);
	localparam int LEN_W      = 13;
	localparam int SAMPLE_W   = 24;
	localparam int FRAC_W     = 16;
	localparam int DELAY_W    = 28;
	localparam int MIN_LEN    = 8;
	localparam int TAP_COUNT  = 4;

	// Read position in samples with fraction; holds the line length shifted up.
	localparam int POS_W  = LEN_W + FRAC_W;
	// Horner accumulator and product widths.
	localparam int ACC_W  = SAMPLE_W + 5;
	localparam int PROD_W = ACC_W + FRAC_W + 1;

	// Depth of the command queue between front and back.
	localparam int CMD_DEPTH = 2;

	// Item operation codes.
	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_READ  = 1'b1;

	typedef logic signed [SAMPLE_W-1:0] sample_t;
	typedef logic [IDX_W-1:0]           idx_t;
	typedef logic [LEN_W-1:0]           len_t;
	typedef logic [FRAC_W-1:0]          frac_t;
	typedef logic [DELAY_W-1:0]         delay_t;
	typedef logic signed [ACC_W-1:0]    acc_t;

	// One decoded command: a store write, or a read at a tap index and fraction.
	typedef struct packed {
		logic    is_read;
		idx_t    addr;
		len_t    len;
		frac_t   frac;
		sample_t left;
		sample_t right;
	} cmd_t;

endpackage

### sv/shfd_in_if.sv
// Input item channel.
interface shfd_in_if import shfd_pkg::*; ();
	logic    valid;
	logic    ready;
	logic    operation;
	sample_t sample_left;
	sample_t sample_right;
	delay_t  delay_amount;

	modport source (
		output valid, operation, sample_left, sample_right, delay_amount,
		input  ready
	);
	modport sink (
		input  valid, operation, sample_left, sample_right, delay_amount,
		output ready
	);
endinterface

### sv/shfd_out_if.sv
// Result channel.
interface shfd_out_if import shfd_pkg::*; ();
	logic    valid;
	logic    ready;
	sample_t out_left;
	sample_t out_right;

	modport source (
		output valid, out_left, out_right,
		input  ready
	);
	modport sink (
		input  valid, out_left, out_right,
		output ready
	);
endinterface

### sv/stereo_hermite_fractional_delay.sv
// Stereo fractional delay line with 4-point cubic Hermite interpolation.
// Items arrive on the item channel and transfer when valid and ready are both high.
// A write item (operation 0) stores one stereo sample and gives no result; a read
// item (operation 1) gives one interpolated stereo result on the result channel.
// The user must write the line length register (cfg_we, cfg_wdata) only while
// idle; the block does not enforce this. A write holds the store port while it is
// taken from the queue; a read holds the back end while it takes the command,
// makes 4 single-port store reads, waits for the last read data, forms the
// coefficients, runs 3 multiply and accumulate steps and loads the output register.
// The back end takes no new command until the read is done.
// A front stage and a two-entry command queue let items keep coming in while the
// back end works or the receiver stalls; once both are full, ready drops.
// A stalled result holds in the output register and holds up the next read, with
// the commands behind it. After reset a pass clears all 4096 store entries, taking
// no item meanwhile; line length resets to 4096 and the write index to zero.
module stereo_hermite_fractional_delay import shfd_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  len_t       cfg_wdata,
	shfd_in_if.sink    item,
	shfd_out_if.source result
);

	logic clear_done;
	logic push_valid;
	logic push_ready;
	cmd_t push_cmd;
	logic pop_valid;
	logic pop_ready;
	cmd_t pop_cmd;

	// Item intake and read position computation.
	shfd_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.clear_done(clear_done),
		.item      (item),
		.push_valid(push_valid),
		.push_cmd  (push_cmd),
		.push_ready(push_ready)
	);

	// Command queue.
	shfd_cmd_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_valid(push_valid),
		.push_cmd  (push_cmd),
		.push_ready(push_ready),
		.pop_valid (pop_valid),
		.pop_cmd   (pop_cmd),
		.pop_ready (pop_ready)
	);

	// Store access and interpolation.
	shfd_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (pop_valid),
		.cmd       (pop_cmd),
		.cmd_ready (pop_ready),
		.clear_done(clear_done),
		.result    (result)
	);

endmodule

### sv/shfd_ram.sv
// Single-port RAM with a registered read.
module shfd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write when enabled, and read the addressed word every cycle.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata_q <= mem_q[addr];
	end

	assign rdata = rdata_q;

endmodule

### sv/shfd_front.sv
// Front end: takes items, tracks the write index and turns reads into tap positions.
module shfd_front import shfd_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  len_t       cfg_wdata,
	input  logic       clear_done,
	shfd_in_if.sink    item,
	output logic       push_valid,
	output cmd_t       push_cmd,
	input  logic       push_ready
);

	logic    v_s1;
	logic    op_s1;
	sample_t left_s1;
	sample_t right_s1;
	delay_t  delay_s1;

	len_t    len_q;
	idx_t    wp_q;

	logic              accept;
	logic              push;
	len_t              cfg_len;
	len_t              wp_inc;
	idx_t              wp_next;
	logic [POS_W-1:0]  dly_ext;
	logic [POS_W-1:0]  max_dly;
	logic [POS_W-1:0]  clamped;
	logic [POS_W-1:0]  wp_pos;
	logic [POS_W:0]    diff;
	logic [POS_W-1:0]  pos;

	assign push    = v_s1 && push_ready;
	assign accept  = item.valid && item.ready;
	assign item.ready = clear_done && (!v_s1 || push_ready);

	// Clamp a written line length into the usable range.
	always_comb begin
		if (cfg_wdata < LEN_W'(MIN_LEN)) begin
			cfg_len = LEN_W'(MIN_LEN);
		end else if (cfg_wdata > LEN_W'(LINE_DEPTH)) begin
			cfg_len = LEN_W'(LINE_DEPTH);
		end else begin
			cfg_len = cfg_wdata;
		end
	end

	// Next write index, wrapping at the line length.
	assign wp_inc  = LEN_W'(wp_q) + LEN_W'(1);
	assign wp_next = (wp_inc == len_q) ? '0 : wp_inc[IDX_W-1:0];

	// Read position: write index minus the clamped delay, wrapped into the line.
	always_comb begin
		dly_ext = POS_W'(delay_s1);
		max_dly = {len_q - LEN_W'(TAP_COUNT), {FRAC_W{1'b0}}};
		clamped = (dly_ext > max_dly) ? max_dly : dly_ext;
		wp_pos  = POS_W'({wp_q, {FRAC_W{1'b0}}});
		diff    = {1'b0, wp_pos} - {1'b0, clamped};
		if (diff[POS_W]) begin
			pos = diff[POS_W-1:0] + {len_q, {FRAC_W{1'b0}}};
		end else begin
			pos = diff[POS_W-1:0];
		end
	end

	// Command toward the back end.
	always_comb begin
		push_cmd.is_read = (op_s1 == OP_READ);
		push_cmd.addr    = (op_s1 == OP_READ) ? pos[FRAC_W +: IDX_W] : wp_q;
		push_cmd.len     = len_q;
		push_cmd.frac    = pos[FRAC_W-1:0];
		push_cmd.left    = left_s1;
		push_cmd.right   = right_s1;
	end
	assign push_valid = v_s1;

	// Input stage register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (accept) begin
			v_s1 <= 1'b1;
		end else if (push) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1    <= item.operation;
			left_s1  <= item.sample_left;
			right_s1 <= item.sample_right;
			delay_s1 <= item.delay_amount;
		end
	end

	// Line length register and write index.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= LEN_W'(LINE_DEPTH);
			wp_q  <= '0;
		end else if (cfg_we) begin
			len_q <= cfg_len;
			if (LEN_W'(wp_q) >= cfg_len) begin
				wp_q <= '0;
			end
		end else if (push && (op_s1 == OP_WRITE)) begin
			wp_q <= wp_next;
		end
	end

endmodule

### sv/shfd_cmd_fifo.sv
// Short command queue between the front and back ends.
module shfd_cmd_fifo import shfd_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push_valid,
	input  cmd_t push_cmd,
	output logic push_ready,
	output logic pop_valid,
	output cmd_t pop_cmd,
	input  logic pop_ready
);

	localparam int PTR_W = $clog2(CMD_DEPTH);
	localparam int CNT_W = $clog2(CMD_DEPTH + 1);

	cmd_t             mem_q [CMD_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;
	logic             do_push;
	logic             do_pop;

	assign push_ready = (cnt_q != CNT_W'(CMD_DEPTH));
	assign pop_valid  = (cnt_q != '0);
	assign pop_cmd    = mem_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	// Entry storage.
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_cmd;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(CMD_DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(CMD_DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end
	end

endmodule

### sv/shfd_back.sv
// Back end: clears the store, performs writes, fetches taps and runs the Hermite kernel.
module shfd_back import shfd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cmd_valid,
	input  cmd_t        cmd,
	output logic        cmd_ready,
	output logic        clear_done,
	shfd_out_if.source  result
);

	localparam logic [2:0] S_CLEAR = 3'd0;
	localparam logic [2:0] S_IDLE  = 3'd1;
	localparam logic [2:0] S_FETCH = 3'd2;
	localparam logic [2:0] S_LAST  = 3'd3;
	localparam logic [2:0] S_COEF  = 3'd4;
	localparam logic [2:0] S_MUL   = 3'd5;
	localparam logic [2:0] S_ACC   = 3'd6;
	localparam logic [2:0] S_OUT   = 3'd7;

	localparam int NCH    = 2;
	localparam int RAM_W  = 2 * SAMPLE_W;
	localparam int TCNT_W = $clog2(TAP_COUNT);
	localparam int NCOEF  = 3;
	localparam int K_W    = $clog2(NCOEF);

	logic [2:0]                state_q;
	idx_t                      clr_q;
	idx_t                      addr_q;
	len_t                      len_q;
	frac_t                     frac_q;
	logic [TCNT_W-1:0]         tap_cnt_q;
	logic                      rd_pend_q;
	logic [K_W-1:0]            k_q;
	sample_t                   tap_q  [NCH][TAP_COUNT];
	acc_t                      coef_q [NCH][NCOEF];
	acc_t                      acc_q  [NCH];
	logic signed [PROD_W-1:0]  prod_q [NCH];
	logic                      out_valid_q;
	sample_t                   out_q  [NCH];

	logic                      ram_we;
	idx_t                      ram_addr;
	logic [RAM_W-1:0]          ram_wdata;
	logic [RAM_W-1:0]          ram_rdata;
	sample_t                   rd_smp [NCH];
	idx_t                      addr_next;
	idx_t                      start_addr;
	acc_t                      d0 [NCH];
	acc_t                      d1 [NCH];
	acc_t                      d2 [NCH];
	acc_t                      d3 [NCH];
	acc_t                      acc_step [NCH];
	sample_t                   sat [NCH];
	logic                      out_load;

	function automatic acc_t ext(input sample_t x);
		return {{(ACC_W - SAMPLE_W){x[SAMPLE_W-1]}}, x};
	endfunction

	assign clear_done = (state_q != S_CLEAR);
	assign cmd_ready  = (state_q == S_IDLE);
	assign rd_smp[0]  = ram_rdata[RAM_W-1:SAMPLE_W];
	assign rd_smp[1]  = ram_rdata[SAMPLE_W-1:0];

	// Tap address stepping, wrapping at the line length.
	assign addr_next  = ((LEN_W'(addr_q) + LEN_W'(1)) == len_q) ? '0 : addr_q + IDX_W'(1);
	assign start_addr = (cmd.addr == '0) ? IDX_W'(cmd.len - LEN_W'(1)) : cmd.addr - IDX_W'(1);

	// Store port selection.
	always_comb begin
		ram_we    = 1'b0;
		ram_addr  = addr_q;
		ram_wdata = '0;
		unique case (state_q)
			S_CLEAR: begin
				ram_we   = 1'b1;
				ram_addr = clr_q;
			end
			S_IDLE: begin
				ram_addr = cmd.addr;
				if (cmd_valid && !cmd.is_read) begin
					ram_we    = 1'b1;
					ram_wdata = {cmd.left, cmd.right};
				end
			end
			default: begin
				ram_addr = addr_q;
			end
		endcase
	end

	shfd_ram #(
		.WIDTH(RAM_W),
		.DEPTH(LINE_DEPTH)
	) u_store (
		.clk  (clk),
		.we   (ram_we),
		.addr (ram_addr),
		.wdata(ram_wdata),
		.rdata(ram_rdata)
	);

	// Doubled Hermite coefficients from the four taps of each channel.
	always_comb begin
		for (int c = 0; c < NCH; c++) begin
			d0[c] = ext(tap_q[c][1]) + ext(tap_q[c][1]);
			d1[c] = ext(tap_q[c][2]) - ext(tap_q[c][0]);
			d2[c] = ext(tap_q[c][0]) + ext(tap_q[c][0])
				- (ext(tap_q[c][1]) <<< 2) - ext(tap_q[c][1])
				+ (ext(tap_q[c][2]) <<< 2) - ext(tap_q[c][3]);
			d3[c] = ext(tap_q[c][3]) - ext(tap_q[c][0])
				+ ((ext(tap_q[c][1]) - ext(tap_q[c][2])) <<< 1)
				+ (ext(tap_q[c][1]) - ext(tap_q[c][2]));
		end
	end

	// Horner step: floored product plus the next coefficient.
	always_comb begin
		for (int c = 0; c < NCH; c++) begin
			acc_step[c] = ACC_W'(prod_q[c] >>> FRAC_W) + coef_q[c][k_q];
		end
	end

	// Halve with rounding half up, then saturate to the sample range.
	always_comb begin
		logic signed [ACC_W:0] rs;
		for (int c = 0; c < NCH; c++) begin
			rs = $signed({acc_q[c][ACC_W-1], acc_q[c]} + (ACC_W + 1)'(1)) >>> 1;
			if ((&rs[ACC_W:SAMPLE_W-1]) || !(|rs[ACC_W:SAMPLE_W-1])) begin
				sat[c] = rs[SAMPLE_W-1:0];
			end else if (rs[ACC_W]) begin
				sat[c] = {1'b1, {(SAMPLE_W - 1){1'b0}}};
			end else begin
				sat[c] = {1'b0, {(SAMPLE_W - 1){1'b1}}};
			end
		end
	end

	assign out_load = (state_q == S_OUT) && (!out_valid_q || result.ready);

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_CLEAR;
			clr_q     <= '0;
			tap_cnt_q <= '0;
			k_q       <= '0;
			rd_pend_q <= 1'b0;
		end else begin
			rd_pend_q <= (state_q == S_FETCH);
			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + IDX_W'(1);
					if (clr_q == IDX_W'(LINE_DEPTH - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (cmd_valid && cmd.is_read) begin
						tap_cnt_q <= '0;
						state_q   <= S_FETCH;
					end
				end
				S_FETCH: begin
					tap_cnt_q <= tap_cnt_q + TCNT_W'(1);
					if (tap_cnt_q == TCNT_W'(TAP_COUNT - 1)) begin
						state_q <= S_LAST;
					end
				end
				S_LAST: begin
					state_q <= S_COEF;
				end
				S_COEF: begin
					k_q     <= K_W'(NCOEF - 1);
					state_q <= S_MUL;
				end
				S_MUL: begin
					state_q <= S_ACC;
				end
				S_ACC: begin
					if (k_q == '0) begin
						state_q <= S_OUT;
					end else begin
						k_q     <= k_q - K_W'(1);
						state_q <= S_MUL;
					end
				end
				S_OUT: begin
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && cmd_valid && cmd.is_read) begin
			addr_q <= start_addr;
			len_q  <= cmd.len;
			frac_q <= cmd.frac;
		end else if (state_q == S_FETCH) begin
			addr_q <= addr_next;
		end
		if (rd_pend_q) begin
			for (int c = 0; c < NCH; c++) begin
				for (int t = 0; t < TAP_COUNT - 1; t++) begin
					tap_q[c][t] <= tap_q[c][t+1];
				end
				tap_q[c][TAP_COUNT-1] <= rd_smp[c];
			end
		end
		for (int c = 0; c < NCH; c++) begin
			if (state_q == S_COEF) begin
				coef_q[c][0] <= d0[c];
				coef_q[c][1] <= d1[c];
				coef_q[c][2] <= d2[c];
				acc_q[c]     <= d3[c];
			end else if (state_q == S_ACC) begin
				acc_q[c] <= acc_step[c];
			end
			if (state_q == S_MUL) begin
				prod_q[c] <= PROD_W'(acc_q[c]) * PROD_W'($signed({1'b0, frac_q}));
			end
			if (out_load) begin
				out_q[c] <= sat[c];
			end
		end
	end

	// Output register; it is refilled only once the held result is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign result.valid     = out_valid_q;
	assign result.out_left  = out_q[0];
	assign result.out_right = out_q[1];

endmodule
